// ===== design/scc_pkg.sv =====
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and codes for the sector cache directory.
// ----------------------------------------------------------------------------
package scc_pkg;

  typedef enum logic [1:0] {
    OP_ACCESS  = 2'd0,
    OP_RELEASE = 2'd1,
    OP_FLUSH   = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_PINNED = 2'd1;
  localparam logic [1:0] STATUS_NOREL  = 2'd2;

  // most write-backs one flush transaction may report
  localparam int unsigned RESULT_CAP = 64;

  typedef struct packed {
    op_e         op;
    logic [31:0] sector;
    logic        dirty;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot;
    logic        hit;
    logic        fill;
    logic        writeback;
    logic [31:0] writeback_sector;
    logic        last;
  } result_t;

endpackage

// ===== design/scc_front.sv =====
// ----------------------------------------------------------------------------
// scc_front
// Input side: takes requests, decodes the function and queues them.
// ----------------------------------------------------------------------------
module scc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [1:0]    func_i,
  input  logic [31:0]   sector_i,
  input  logic          dirty_i,
  output logic          q_valid_o,
  output scc_pkg::item_t q_item_o,
  input  logic          q_pop_i
);
  import scc_pkg::*;

  item_t      mem_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  item_t      item_in;

  always_comb begin
    unique case (func_i)
      2'd0:    item_in.op = OP_ACCESS;
      2'd1:    item_in.op = OP_RELEASE;
      2'd2:    item_in.op = OP_FLUSH;
      default: item_in.op = OP_CLEAR;
    endcase
    item_in.sector = sector_i;
    item_in.dirty  = dirty_i;
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q ^ push;
    rp_d  = rp_q ^ q_pop_i;
    cnt_d = cnt_q + 2'(push) - 2'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= item_in;
    end
  end

endmodule

// ===== design/scc_back.sv =====
// ----------------------------------------------------------------------------
// scc_back
// Directory sequencer: lookup, fill, clock victim scan and flush walk.
// ----------------------------------------------------------------------------
module scc_back #(
  parameter int unsigned ENTRIES  = 64,
  parameter int unsigned PIN_BITS = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  scc_pkg::item_t  q_item_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output scc_pkg::result_t out_o
);
  import scc_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned KW = $clog2(RESULT_CAP + 1);
  localparam logic [CW-1:0] ENTRIES_C = CW'(ENTRIES);
  localparam logic [CW-1:0] LAST_IDX  = CW'(ENTRIES - 1);
  localparam logic [KW-1:0] CAP_C     = KW'(RESULT_CAP);
  localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_LK_RD   = 9'b000000010,
    ST_LK_CMP  = 9'b000000100,
    ST_VC_RD   = 9'b000001000,
    ST_VC_CHK  = 9'b000010000,
    ST_FL_SCAN = 9'b000100000,
    ST_FL_DATA = 9'b001000000,
    ST_FL_END  = 9'b010000000,
    ST_EMIT    = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] idx_q, idx_d, eu_q, eu_d;
  logic          pass_q, pass_d;
  logic [KW-1:0] k_q, k_d;
  item_t         cur_q, cur_d;
  result_t       res_q, res_d;
  logic          pend_v_q, pend_v_d;
  logic [5:0]    pend_slot_q, pend_slot_d;
  logic [31:0]   pend_sec_q, pend_sec_d;
  logic [ENTRIES-1:0] pin_vld_q, pin_vld_d, dirty_q, dirty_d, ref_q, ref_d;

  logic [31:0]         sec_mem [ENTRIES];
  logic [PIN_BITS-1:0] pin_mem [ENTRIES];
  logic [31:0]         sec_rd_q;
  logic [PIN_BITS-1:0] pin_rd_q;
  logic [IW-1:0]       rd_addr_q;
  logic                sec_we, pin_we;
  logic [IW-1:0]       wr_addr;
  logic [31:0]         sec_wd;
  logic [PIN_BITS-1:0] pin_wd, pin_eff;

  logic    out_v_q, out_v_d, out_free, out_ld;
  result_t out_q, out_nx;

  logic [IW-1:0] ix;
  logic [5:0]    ix_slot;

  assign ix       = idx_q[IW-1:0];
  assign ix_slot  = 6'(ix);
  assign pin_eff  = pin_vld_q[rd_addr_q] ? pin_rd_q : '0;
  assign out_free = !out_v_q || !out_stall_i;
  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    eu_d        = eu_q;
    pass_d      = pass_q;
    k_d         = k_q;
    cur_d       = cur_q;
    res_d       = res_q;
    pend_v_d    = pend_v_q;
    pend_slot_d = pend_slot_q;
    pend_sec_d  = pend_sec_q;
    pin_vld_d   = pin_vld_q;
    dirty_d     = dirty_q;
    ref_d       = ref_q;
    sec_we      = 1'b0;
    pin_we      = 1'b0;
    wr_addr     = ix;
    sec_wd      = cur_q.sector;
    pin_wd      = PIN_BITS'(1);
    q_pop_o     = 1'b0;
    out_ld      = 1'b0;
    out_nx      = res_q;

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o  = 1'b1;
          cur_d    = q_item_i;
          idx_d    = '0;
          k_d      = '0;
          pend_v_d = 1'b0;
          if (q_item_i.op == OP_ACCESS || q_item_i.op == OP_RELEASE) begin
            state_d = ST_LK_RD;
          end else begin
            state_d = ST_FL_SCAN;
          end
        end
      end
      ST_LK_RD: begin
        if (idx_q < eu_q) begin
          state_d = ST_LK_CMP;
        end else if (cur_q.op == OP_RELEASE) begin
          res_d   = '{STATUS_NOREL, 6'd0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b1};
          state_d = ST_EMIT;
        end else if (eu_q < ENTRIES_C) begin
          // free slot at the end of the used range
          sec_we        = 1'b1;
          pin_we        = 1'b1;
          pin_vld_d[ix] = 1'b1;
          dirty_d[ix]   = cur_q.dirty;
          ref_d[ix]     = 1'b1;
          eu_d          = eu_q + 1'b1;
          res_d   = '{STATUS_OK, ix_slot, 1'b0, 1'b1, 1'b0, 32'd0, 1'b1};
          state_d = ST_EMIT;
        end else begin
          idx_d   = '0;
          pass_d  = 1'b0;
          state_d = ST_VC_RD;
        end
      end
      ST_LK_CMP: begin
        if (sec_rd_q == cur_q.sector) begin
          pin_we        = 1'b1;
          pin_vld_d[ix] = 1'b1;
          if (cur_q.op == OP_ACCESS) begin
            pin_wd      = (pin_eff == PIN_MAX) ? pin_eff : pin_eff + 1'b1;
            dirty_d[ix] = dirty_q[ix] | cur_q.dirty;
            ref_d[ix]   = 1'b1;
            res_d = '{STATUS_OK, ix_slot, 1'b1, 1'b0, 1'b0, 32'd0, 1'b1};
          end else begin
            pin_wd = (pin_eff != '0) ? pin_eff - 1'b1 : pin_eff;
            res_d  = '{STATUS_OK, ix_slot, 1'b0, 1'b0, 1'b0, 32'd0, 1'b1};
          end
          state_d = ST_EMIT;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_LK_RD;
        end
      end
      ST_VC_RD: begin
        state_d = ST_VC_CHK;
      end
      ST_VC_CHK: begin
        if (pin_eff == '0 && !ref_q[ix]) begin
          sec_we        = 1'b1;
          pin_we        = 1'b1;
          pin_vld_d[ix] = 1'b1;
          dirty_d[ix]   = cur_q.dirty;
          ref_d[ix]     = 1'b1;
          res_d = '{STATUS_OK, ix_slot, 1'b0, 1'b1, dirty_q[ix],
                    dirty_q[ix] ? sec_rd_q : 32'd0, 1'b1};
          state_d = ST_EMIT;
        end else begin
          // second chance: referenced unpinned slot loses its bit
          if (pin_eff == '0) begin
            ref_d[ix] = 1'b0;
          end
          if (idx_q == LAST_IDX) begin
            if (pass_q) begin
              res_d   = '{STATUS_PINNED, 6'd0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b1};
              state_d = ST_EMIT;
            end else begin
              pass_d  = 1'b1;
              idx_d   = '0;
              state_d = ST_VC_RD;
            end
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_VC_RD;
          end
        end
      end
      ST_FL_SCAN: begin
        if (idx_q >= eu_q || k_q == CAP_C) begin
          state_d = ST_FL_END;
        end else if (dirty_q[ix]) begin
          dirty_d[ix] = 1'b0;
          state_d     = ST_FL_DATA;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_FL_DATA: begin
        // one write-back held back so the final one can carry last
        if (!pend_v_q || out_free) begin
          if (pend_v_q) begin
            out_ld = 1'b1;
            out_nx = '{STATUS_OK, pend_slot_q, 1'b0, 1'b0, 1'b1, pend_sec_q, 1'b0};
          end
          pend_v_d    = 1'b1;
          pend_slot_d = ix_slot;
          pend_sec_d  = sec_rd_q;
          k_d         = k_q + 1'b1;
          idx_d       = idx_q + 1'b1;
          state_d     = ST_FL_SCAN;
        end
      end
      ST_FL_END: begin
        if (out_free) begin
          out_ld = 1'b1;
          if (pend_v_q) begin
            out_nx = '{STATUS_OK, pend_slot_q, 1'b0, 1'b0, 1'b1, pend_sec_q, 1'b1};
          end else begin
            out_nx = '{STATUS_OK, 6'd0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b1};
          end
          if (cur_q.op == OP_CLEAR) begin
            eu_d      = '0;
            pin_vld_d = '0;
            dirty_d   = '0;
            ref_d     = '0;
          end
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_ld  = 1'b1;
          out_nx  = res_q;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_ld) begin
      out_v_d = 1'b1;
    end else if (!out_stall_i) begin
      out_v_d = 1'b0;
    end else begin
      out_v_d = out_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      eu_q      <= '0;
      pass_q    <= 1'b0;
      k_q       <= '0;
      pend_v_q  <= 1'b0;
      pin_vld_q <= '0;
      dirty_q   <= '0;
      ref_q     <= '0;
      out_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      eu_q      <= eu_d;
      pass_q    <= pass_d;
      k_q       <= k_d;
      pend_v_q  <= pend_v_d;
      pin_vld_q <= pin_vld_d;
      dirty_q   <= dirty_d;
      ref_q     <= ref_d;
      out_v_q   <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    res_q       <= res_d;
    pend_slot_q <= pend_slot_d;
    pend_sec_q  <= pend_sec_d;
    if (out_ld) begin
      out_q <= out_nx;
    end
  end

  // directory memories, read every cycle at the walk index
  always_ff @(posedge clk_i) begin
    if (sec_we) begin
      sec_mem[wr_addr] <= sec_wd;
    end
    if (pin_we) begin
      pin_mem[wr_addr] <= pin_wd;
    end
    sec_rd_q  <= sec_mem[ix];
    pin_rd_q  <= pin_mem[ix];
    rd_addr_q <= ix;
  end

endmodule

// ===== design/sector_cache_second_chance.sv =====
// ----------------------------------------------------------------------------
// sector_cache_second_chance
// Directory of a disk-sector cache with second-chance replacement.
// ----------------------------------------------------------------------------
// Requests enter a two-deep queue and are carried out one at a time by a
// sequencer that walks the directory slot by slot, a read state and then a
// compare or check state per slot, through the registered read port of the
// sector and pin memories. A miss with a full directory adds a victim scan of
// up to two sweeps over all ENTRIES slots. A flush visits each used slot and
// spends an extra state on each dirty one. Results leave through an output
// register, so the queue keeps taking requests while a result waits.
module sector_cache_second_chance #(
  parameter int unsigned ENTRIES  = 64,
  parameter int unsigned PIN_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] sector_i,
  input  logic        dirty_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [5:0]  slot_o,
  output logic        hit_o,
  output logic        fill_o,
  output logic        writeback_o,
  output logic [31:0] writeback_sector_o,
  output logic        last_o
);
  import scc_pkg::*;

  logic    q_valid, q_pop;
  item_t   q_item;
  result_t res;

  scc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .sector_i   (sector_i),
    .dirty_i    (dirty_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  scc_back #(
    .ENTRIES  (ENTRIES),
    .PIN_BITS (PIN_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (res)
  );

  assign status_o           = res.status;
  assign slot_o             = res.slot;
  assign hit_o              = res.hit;
  assign fill_o             = res.fill;
  assign writeback_o        = res.writeback;
  assign writeback_sector_o = res.writeback_sector;
  assign last_o             = res.last;

endmodule

// ===== tb/sector_cache_second_chance_test.sv =====
// ----------------------------------------------------------------------------
// sector_cache_second_chance_test
// Drives access, release, flush and clear transactions into the sector cache
// directory, predicts every result with a clock-replacement model of its
// own and checks each result field by field, with random idling on both sides.
// ----------------------------------------------------------------------------
module sector_cache_second_chance_test;
  import scc_pkg::*;

  localparam int NSLOT   = 64;
  localparam int PIN_TOP = 255;
  localparam int WD_MAX  = 20000;

  class dir_scoreboard;
    int          used;
    logic [31:0] tag_q[NSLOT];
    int          pins[NSLOT];
    bit          dmark[NSLOT];
    bit          rmark[NSLOT];
    result_t     pending[$];
    int          errors;
    int          n_hit, n_fill, n_wb, n_full;

    function void clear_dir();
      used = 0;
      for (int i = 0; i < NSLOT; i++) begin
        tag_q[i] = '0; pins[i] = 0; dmark[i] = 0; rmark[i] = 0;
      end
    endfunction

    function int lookup(logic [31:0] s);
      for (int i = 0; i < used; i++) if (tag_q[i] == s) return i;
      return -1;
    endfunction

    function void push(logic [1:0] st, int sl, bit h, bit f, bit w,
                       logic [31:0] ws, bit l);
      result_t r;
      r.status = st; r.slot = sl[5:0]; r.hit = h; r.fill = f;
      r.writeback = w; r.writeback_sector = ws; r.last = l;
      pending.push_back(r);
    endfunction

    function void note_item(op_e op, logic [31:0] s, bit d);
      int k, v, cnt;
      bit wbd;
      k = lookup(s);
      v = -1;
      cnt = 0;
      if (op == OP_ACCESS) begin
        if (k >= 0) begin
          if (pins[k] < PIN_TOP) pins[k]++;
          dmark[k] |= d; rmark[k] = 1; n_hit++;
          push(STATUS_OK, k, 1, 0, 0, 0, 1);
        end else if (used < NSLOT) begin
          tag_q[used] = s; pins[used] = 1; dmark[used] = d; rmark[used] = 1;
          push(STATUS_OK, used, 0, 1, 0, 0, 1);
          used++; n_fill++;
        end else begin
          // second chance: two sweeps from slot 0
          for (int p = 0; p < 2 && v < 0; p++)
            for (int i = 0; i < NSLOT && v < 0; i++)
              if (pins[i] == 0) begin
                if (rmark[i]) rmark[i] = 0;
                else v = i;
              end
          if (v < 0) begin
            n_full++;
            push(STATUS_PINNED, 0, 0, 0, 0, 0, 1);
          end else begin
            wbd = dmark[v];
            push(STATUS_OK, v, 0, 1, wbd, wbd ? tag_q[v] : 32'd0, 1);
            tag_q[v] = s; pins[v] = 1; dmark[v] = d; rmark[v] = 1;
            n_fill++;
          end
        end
      end else if (op == OP_RELEASE) begin
        if (k < 0) push(STATUS_NOREL, 0, 0, 0, 0, 0, 1);
        else begin
          if (pins[k] > 0) pins[k]--;
          push(STATUS_OK, k, 0, 0, 0, 0, 1);
        end
      end else begin
        for (int i = 0; i < used && cnt < RESULT_CAP; i++)
          if (dmark[i]) begin
            dmark[i] = 0;
            push(STATUS_OK, i, 0, 0, 1, tag_q[i], 0);
            cnt++; n_wb++;
          end
        if (cnt == 0) push(STATUS_OK, 0, 0, 0, 0, 0, 1);
        else pending[$].last = 1;
        if (op == OP_CLEAR) begin
          used = 0;
          for (int i = 0; i < NSLOT; i++) begin
            pins[i] = 0; dmark[i] = 0; rmark[i] = 0;
          end
        end
      end
    endfunction

    function void check_result(result_t a);
      result_t e;
      if (pending.size() == 0) begin
        $error("result with nothing expected: slot %0d", a.slot);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, a.status); errors++;
      end
      if (a.slot !== e.slot) begin
        $error("slot exp %0d got %0d", e.slot, a.slot); errors++;
      end
      if (a.hit !== e.hit) begin
        $error("hit exp %0d got %0d", e.hit, a.hit); errors++;
      end
      if (a.fill !== e.fill) begin
        $error("fill exp %0d got %0d", e.fill, a.fill); errors++;
      end
      if (a.writeback !== e.writeback) begin
        $error("writeback exp %0d got %0d", e.writeback, a.writeback); errors++;
      end
      if (a.writeback_sector !== e.writeback_sector) begin
        $error("writeback_sector exp %h got %h", e.writeback_sector,
               a.writeback_sector);
        errors++;
      end
      if (a.last !== e.last) begin
        $error("last exp %0d got %0d", e.last, a.last); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [1:0]  func_i = '0;
  logic [31:0] sector_i = '0;
  logic        dirty_i = 0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic [1:0]  status_o;
  logic [5:0]  slot_o;
  logic        hit_o, fill_o, writeback_o, last_o;
  logic [31:0] writeback_sector_o;

  sector_cache_second_chance dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  dir_scoreboard sb = new();
  bit calm;
  int idle_cycles = 0;
  logic [31:0] pool[16];

  // result side: random stall, check at each accepted transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        result_t r;
        r.status = status_o; r.slot = slot_o; r.hit = hit_o; r.fill = fill_o;
        r.writeback = writeback_o; r.writeback_sector = writeback_sector_o;
        r.last = last_o;
        sb.check_result(r);
      end
      out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < 31);
    end
  end

  // watchdog on cycles without any accepted transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WD_MAX) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // valid drops only on an idle cycle, so back to back transactions keep it high
  task automatic send(op_e op, logic [31:0] s, bit d);
    while (!calm && $urandom_range(99) < 31) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1; func_i <= op; sector_i <= s; dirty_i <= d;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_item(op, s, d);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_sector();
    return ($urandom_range(99) < 75) ? pool[$urandom_range(15)] : $urandom;
  endfunction

  initial begin
    int r;
    op_e op;
    sb.clear_dir();
    sb.errors = 0;
    calm = 0;
    // half the pool reuses sectors that the directed part fills
    for (int i = 0; i < 16; i++) pool[i] = (i < 8) ? 32'h100 + i : $urandom;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: extremes, every op, empty flush, stale release, saturation
    send(OP_FLUSH, 32'h0, 0);
    send(OP_RELEASE, 32'hFFFF_FFFF, 0);
    send(OP_ACCESS, 32'h0, 1);
    send(OP_ACCESS, 32'hFFFF_FFFF, 0);
    send(OP_ACCESS, 32'h0, 0);
    send(OP_RELEASE, 32'h0, 0);
    send(OP_RELEASE, 32'h0, 0);
    send(OP_RELEASE, 32'h0, 0);
    send(OP_FLUSH, 32'hAAAA_5555, 1);
    calm = 1;
    for (int i = 0; i < 258; i++) send(OP_ACCESS, 32'h5555_AAAA, i[0]);
    calm = 0;
    send(OP_CLEAR, 32'h0, 0);
    // fill all slots pinned, then a miss finds no victim
    for (int i = 0; i < NSLOT; i++) send(OP_ACCESS, 32'h100 + i, i[1]);
    send(OP_ACCESS, 32'h7777, 1);
    // unpin a few, evict with dirty write-back
    for (int i = 0; i < 8; i++) send(OP_RELEASE, 32'h100 + 2 * i, 0);
    send(OP_ACCESS, 32'h8888, 0);
    send(OP_ACCESS, 32'h9999, 1);
    send(OP_FLUSH, 32'h0, 0);
    drain();

    // random: access/release on a full directory, with rare flushes and clears
    for (int n = 0; n < 26; n++) begin
      calm = (n >= 10 && n < 16);
      r = $urandom_range(99);
      if (r < 55) op = OP_ACCESS;
      else if (r < 92) op = OP_RELEASE;
      else if (r < 97) op = OP_FLUSH;
      else op = OP_CLEAR;
      send(op, pick_sector(), $urandom_range(1));
    end
    calm = 0;
    drain();

    $display("covered %0d hits, %0d fills, %0d write-backs, %0d all-pinned misses",
             sb.n_hit, sb.n_fill, sb.n_wb, sb.n_full);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== sector_cache_second_chance.f =====
design/scc_pkg.sv
design/scc_front.sv
design/scc_back.sv
design/sector_cache_second_chance.sv
tb/sector_cache_second_chance_test.sv
